// ----- src/keyframe_track_sampler_macros.svh -----
// ----------------------------------------------------------------------------
// keyframe_track_sampler assertion macros
// Shared assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_TRACK_SAMPLER_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define KTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/kts_pkg.sv -----
// ----------------------------------------------------------------------------
// kts_pkg
// Types and constants for the keyframe track sampler.
// ----------------------------------------------------------------------------
package kts_pkg;
  localparam int unsigned MaxKeysDefault = 64;
  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 7;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [2:0] REG_KEY_COUNT = 3'd0;
  localparam logic [2:0] REG_CONST_X   = 3'd1;
  localparam logic [2:0] REG_CONST_Y   = 3'd2;
  localparam logic [2:0] REG_CONST_Z   = 3'd3;
  localparam logic [2:0] REG_CONST_W   = 3'd4;

  typedef struct packed {
    logic        opcode;
    logic [5:0]  key_index;
    logic [31:0] key_time;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic [31:0] sample_time;
  } item_t;
endpackage

// ----- src/kts_front.sv -----
// ----------------------------------------------------------------------------
// kts_front
// Accepts items and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module kts_front
  import kts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  item_t in_item,
  output logic  q_valid,
  output item_t q_item,
  input  logic  q_pop
);
  item_t      mem_r [2];
  logic       wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end
endmodule

// ----- src/kts_back.sv -----
// ----------------------------------------------------------------------------
// kts_back
// Key table, linear search, serial divider and interpolation sequencer.
// ----------------------------------------------------------------------------
module kts_back
  import kts_pkg::*;
#(
  parameter int unsigned MAX_KEYS = MaxKeysDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [CountW-1:0] key_count,
  input  logic [31:0]       const_x,
  input  logic [31:0]       const_y,
  input  logic [31:0]       const_z,
  input  logic [31:0]       const_w,
  output logic              out_valid,
  output logic [31:0]       out_x,
  output logic [31:0]       out_y,
  output logic [31:0]       out_z,
  output logic [31:0]       out_w
);
  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_CMP  = 4'd2;
  localparam logic [3:0] S_PRV  = 4'd3;
  localparam logic [3:0] S_PRV2 = 4'd4;
  localparam logic [3:0] S_NXT  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_MUL  = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [31:0]  tmem [MAX_KEYS];
  logic [127:0] vmem [MAX_KEYS];
  logic [31:0]  trd_r;
  logic [127:0] vrd_r;
  logic [AW-1:0] raddr;

  logic [3:0]    st_r, st_nxt;
  logic [NW-1:0] i_r, i_nxt, n_r, n_nxt;
  logic [31:0]   t_r, t_nxt, t0_r, t0_nxt;
  logic [127:0]  a_r, a_nxt, b_r, b_nxt;
  logic [47:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [16:0]   f_r, f_nxt;
  logic [4:0]    dc_r, dc_nxt;
  logic [1:0]    lc_r, lc_nxt;
  logic [63:0]   pa_r, pa_nxt, pb_r, pb_nxt;
  logic [127:0]  res_r, res_nxt;
  logic          ov_r, ov_nxt;

  logic [31:0]   av, bv;
  logic [48:0]   sub;
  logic [63:0]   sum;

  assign av  = a_r[lc_r*32 +: 32];
  assign bv  = b_r[lc_r*32 +: 32];
  assign sub = {rem_r, 1'b0} - {17'd0, den_r};
  assign sum = pa_r + pb_r;

  always_comb begin
    raddr = i_r[AW-1:0];
    if (st_r == S_CMP && trd_r > t_r && i_r != '0) begin
      raddr = AW'(i_r - 1'b1);
    end else if (st_r == S_PRV) begin
      raddr = AW'(i_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.opcode == OP_WRITE && 32'(q_item.key_index) < MAX_KEYS) begin
      tmem[AW'(q_item.key_index)] <= q_item.key_time;
      vmem[AW'(q_item.key_index)] <= {q_item.w, q_item.z, q_item.y, q_item.x};
    end
    trd_r <= tmem[raddr];
    vrd_r <= vmem[raddr];
  end

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; n_nxt = n_r; t_nxt = t_r; t0_nxt = t0_r;
    a_nxt = a_r; b_nxt = b_r; rem_nxt = rem_r; den_nxt = den_r; f_nxt = f_r;
    dc_nxt = dc_r; lc_nxt = lc_r; pa_nxt = pa_r; pb_nxt = pb_r;
    res_nxt = res_r; ov_nxt = 1'b0; q_pop = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.opcode == OP_SAMPLE) begin
            t_nxt = q_item.sample_time;
            i_nxt = '0;
            if (32'(key_count) > MAX_KEYS) n_nxt = NW'(MAX_KEYS);
            else n_nxt = NW'(key_count);
            if (key_count == '0) begin
              res_nxt = {const_w, const_z, const_y, const_x};
              st_nxt = S_OUT;
            end else begin
              st_nxt = S_RD;
            end
          end
        end
      end
      S_RD: st_nxt = S_CMP;
      S_CMP: begin
        if (trd_r > t_r) begin
          if (i_r == '0) begin
            res_nxt = vrd_r; st_nxt = S_OUT;
          end else begin
            b_nxt = vrd_r; den_nxt = trd_r; st_nxt = S_PRV;
          end
        end else if (i_r + 1'b1 == n_r) begin
          res_nxt = vrd_r; st_nxt = S_OUT;
        end else begin
          i_nxt = i_r + 1'b1; st_nxt = S_RD;
        end
      end
      S_PRV: st_nxt = S_PRV2;
      S_PRV2: begin
        a_nxt = vrd_r; t0_nxt = trd_r;
        if (trd_r == t_r) begin
          res_nxt = vrd_r; st_nxt = S_OUT;
        end else begin
          st_nxt = S_NXT;
        end
      end
      S_NXT: begin
        den_nxt = den_r - t0_r;
        rem_nxt = 48'(t_r - t0_r);
        f_nxt = '0; dc_nxt = '0; st_nxt = S_DIV;
      end
      S_DIV: begin
        if (!sub[48]) begin
          rem_nxt = sub[47:0]; f_nxt = {f_r[15:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[46:0], 1'b0}; f_nxt = {f_r[15:0], 1'b0};
        end
        dc_nxt = dc_r + 5'd1;
        if (dc_r == 5'd15) begin
          lc_nxt = '0; st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        pa_nxt = 64'($signed(av) * $signed({1'b0, 17'h10000 - f_r}));
        pb_nxt = 64'($signed(bv) * $signed({1'b0, f_r}));
        st_nxt = S_SUM;
      end
      S_SUM: begin
        res_nxt[lc_r*32 +: 32] = sum[47:16];
        lc_nxt = lc_r + 2'd1;
        st_nxt = (lc_r == 2'd3) ? S_OUT : S_MUL;
      end
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    i_r <= i_nxt; n_r <= n_nxt; t_r <= t_nxt; t0_r <= t0_nxt;
    a_r <= a_nxt; b_r <= b_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
    f_r <= f_nxt; dc_r <= dc_nxt; lc_r <= lc_nxt; pa_r <= pa_nxt;
    pb_r <= pb_nxt; res_r <= res_nxt;
  end

  assign out_valid = ov_r;
  assign out_x = res_r[31:0];
  assign out_y = res_r[63:32];
  assign out_z = res_r[95:64];
  assign out_w = res_r[127:96];
endmodule

// ----- src/keyframe_track_sampler.sv -----
// ----------------------------------------------------------------------------
// keyframe_track_sampler
// Keyframe table with linear-interpolated sampling.
// ----------------------------------------------------------------------------
// channel | signals                         | handshake
// input   | start, in_*                     | start && !busy
// result  | out_valid, out_x..out_w         | one-cycle strobe
// config  | psel, penable, pwrite, paddr... | APB read/write, pready high
// A key write goes straight into the back-end table when it is dequeued.
// A sample reads and compares one key at a time, then runs the bit-serial
// divider and a multiply step and a sum step for each of the four components.
// The serial key scan and the bit-serial divider set the rate.
// A two-entry queue decouples acceptance from the sequencer.
// Reset (rst_n, synchronous) clears control and config registers; the table is not.
module keyframe_track_sampler
  import kts_pkg::*;
#(
  parameter int unsigned MAX_KEYS = MaxKeysDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_key_time,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  input  logic [31:0] in_w,
  input  logic [31:0] in_sample_time,
  output logic        out_valid,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_w,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  item_t             in_item, q_item;
  logic              q_valid, q_pop, wr;
  logic [CountW-1:0] key_count_r;
  logic [31:0]       cx_r, cy_r, cz_r, cw_r;
  logic [2:0]        ridx;

  assign in_item = '{opcode: in_opcode, key_index: in_key_index, key_time: in_key_time,
                     x: in_x, y: in_y, z: in_z, w: in_w, sample_time: in_sample_time};
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
      cx_r <= '0; cy_r <= '0; cz_r <= '0; cw_r <= '0;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_KEY_COUNT: key_count_r <= pwdata[CountW-1:0];
        REG_CONST_X:   cx_r <= pwdata;
        REG_CONST_Y:   cy_r <= pwdata;
        REG_CONST_Z:   cz_r <= pwdata;
        REG_CONST_W:   cw_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_KEY_COUNT: prdata = 32'(key_count_r);
      REG_CONST_X:   prdata = cx_r;
      REG_CONST_Y:   prdata = cy_r;
      REG_CONST_Z:   prdata = cz_r;
      REG_CONST_W:   prdata = cw_r;
      default:       prdata = '0;
    endcase
  end

  kts_front u_front (
    .clk, .rst_n, .start, .busy, .in_item, .q_valid, .q_item, .q_pop
  );

  kts_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop,
    .key_count(key_count_r), .const_x(cx_r), .const_y(cy_r), .const_z(cz_r),
    .const_w(cw_r), .out_valid, .out_x, .out_y, .out_z, .out_w
  );
endmodule

// ----- src/kts_checker.sv -----
// ----------------------------------------------------------------------------
// kts_checker
// Port-level checks for the keyframe track sampler.
// ----------------------------------------------------------------------------
`include "keyframe_track_sampler_macros.svh"
module kts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        pready,
  input logic        psel,
  input logic        penable,
  input logic [31:0] out_x
);
  `KTS_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready, "pready low")
  `KTS_ASSERT_NXT(a_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held")
  `KTS_ASSERT_IMP(a_apb, clk, rst_n, penable, psel, "penable without psel")
  `KTS_ASSERT_IMP(a_known, clk, rst_n, out_valid, !$isunknown(out_x), "result x unknown")
  `KTS_ASSERT_NXT(a_idle, clk, rst_n, !busy && !start && !out_valid, !busy, "busy without item")
endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .pready, .psel, .penable, .out_x
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the keyframe track sampler: key table writes and
// samples are predicted in the bench and each result is compared field by
// field, across several key counts and constant values set over APB.
// ----------------------------------------------------------------------------
module tb_top;
  import kts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumSlots = 64;
  localparam int DrainCycles = 400;
  localparam int CycleLimit = 1500000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
  } sample_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_opcode;
  logic [5:0]  in_key_index;
  logic [31:0] in_key_time;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  logic [31:0] in_w;
  logic [31:0] in_sample_time;
  logic        out_valid;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [31:0] out_w;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [6:0]  key_count;
  logic [31:0] const_val [4];
  logic [31:0] tbl_time [NumSlots];
  sample_t     tbl_val [NumSlots];
  sample_t     expected_samples [$];
  int          err_count;
  int          gap_pct;
  longint      cycle_count;

  keyframe_track_sampler DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_key_index   (in_key_index),
    .in_key_time    (in_key_time),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .in_w           (in_w),
    .in_sample_time (in_sample_time),
    .out_valid      (out_valid),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_w          (out_w),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                 logic [16:0] f);
    logic signed [63:0] s;
    s = $signed({{32{a[31]}}, a}) * $signed({47'd0, 17'h10000 - f})
        + $signed({{32{b[31]}}, b}) * $signed({47'd0, f});
    return s[47:16];
  endfunction

  function automatic sample_t predict_sample(logic [31:0] t);
    sample_t r;
    int n;
    int i;
    logic [47:0] num;
    logic [47:0] f;
    n = (key_count > NumSlots) ? NumSlots : key_count;
    if (n == 0) begin
      r = {const_val[0], const_val[1], const_val[2], const_val[3]};
      return r;
    end
    for (i = 0; i < n; i++)
      if (tbl_time[i] > t) break;
    if (i == 0 || i == n || tbl_time[i-1] == t) begin
      return tbl_val[(i == 0) ? 0 : i - 1];
    end
    num = {16'd0, t - tbl_time[i-1]} << 16;
    f = num / {16'd0, tbl_time[i] - tbl_time[i-1]};
    if (f > 48'd65535) f = 48'd65535;
    r.x = lerp_component(tbl_val[i-1].x, tbl_val[i].x, f[16:0]);
    r.y = lerp_component(tbl_val[i-1].y, tbl_val[i].y, f[16:0]);
    r.z = lerp_component(tbl_val[i-1].z, tbl_val[i].z, f[16:0]);
    r.w = lerp_component(tbl_val[i-1].w, tbl_val[i].w, f[16:0]);
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_valid) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected result transfer");
        err_count++;
      end else begin
        exp_s = expected_samples.pop_front();
        if (out_x !== exp_s.x) begin
          $error("out_x expected %h actual %h", exp_s.x, out_x);
          err_count++;
        end
        if (out_y !== exp_s.y) begin
          $error("out_y expected %h actual %h", exp_s.y, out_y);
          err_count++;
        end
        if (out_z !== exp_s.z) begin
          $error("out_z expected %h actual %h", exp_s.z, out_z);
          err_count++;
        end
        if (out_w !== exp_s.w) begin
          $error("out_w expected %h actual %h", exp_s.w, out_w);
          err_count++;
        end
      end
    end
  end

  // called at a falling edge
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_KEY_COUNT) key_count = value[6:0];
    else const_val[idx - 1] = value;
  endtask

  // one input transfer; called and returns at a falling edge
  task automatic send_item(item_t it);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_opcode      <= it.opcode;
    in_key_index   <= it.key_index;
    in_key_time    <= it.key_time;
    in_x           <= it.x;
    in_y           <= it.y;
    in_z           <= it.z;
    in_w           <= it.w;
    in_sample_time <= it.sample_time;
    do @(posedge clk); while (busy);
    if (it.opcode == OP_WRITE) begin
      tbl_time[it.key_index] = it.key_time;
      tbl_val[it.key_index] = {it.x, it.y, it.z, it.w};
    end else begin
      expected_samples.push_back(predict_sample(it.sample_time));
    end
    @(negedge clk);
  endtask

  task automatic write_key(int idx, logic [31:0] t, sample_t v);
    item_t it;
    it = {OP_WRITE, 6'(idx), t, v.x, v.y, v.z, v.w, $urandom()};
    send_item(it);
  endtask

  task automatic sample_at(logic [31:0] t);
    item_t it;
    it = {OP_SAMPLE, 6'($urandom()), $urandom(), $urandom(), $urandom(),
          $urandom(), $urandom(), t};
    send_item(it);
  endtask

  function automatic sample_t rand_value();
    sample_t v;
    v = {$urandom(), $urandom(), $urandom(), $urandom()};
    return v;
  endfunction

  // ascending table with random spacing
  task automatic load_track(int n, logic [31:0] step_max);
    logic [31:0] t;
    t = $urandom_range(1000);
    for (int k = 0; k < n; k++) begin
      write_key(k, t, rand_value());
      t = t + $urandom_range(step_max, 1);
    end
  endtask

  function automatic logic [31:0] pick_time(int n);
    int k;
    k = $urandom_range(n - 1);
    case ($urandom_range(4))
      0: return tbl_time[k];
      1: return tbl_time[k] + $urandom_range(3);
      2: return $urandom();
      default: return tbl_time[k] + $urandom_range(200000);
    endcase
  endfunction

  task automatic test_constant();
    cfg_write(REG_CONST_X, 32'h7fffffff);
    cfg_write(REG_CONST_Y, 32'h80000000);
    cfg_write(REG_CONST_Z, 32'h0);
    cfg_write(REG_CONST_W, 32'hffffffff);
    cfg_write(REG_KEY_COUNT, 7'd0);
    sample_at(32'h0);
    sample_at(32'hffffffff);
    wait_idle();
  endtask

  task automatic test_directed();
    sample_t hi;
    sample_t lo;
    hi = {32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h00010000};
    lo = {32'h80000000, 32'h80000000, 32'h7fffffff, 32'hffff0000};
    write_key(0, 32'h00010000, hi);
    write_key(1, 32'h00020000, lo);
    write_key(2, 32'hffffffff, hi);
    write_key(3, 32'h00000000, lo);
    write_key(63, 32'h12345678, hi);
    wait_idle();
    cfg_write(REG_KEY_COUNT, 7'd3);
    sample_at(32'h0);        // before first key, clamps to key 0
    sample_at(32'h00010000); // exact hit
    sample_at(32'h00018000); // midway
    sample_at(32'h0001ffff);
    sample_at(32'h00020001);
    sample_at(32'hffffffff); // last key
    wait_idle();
    cfg_write(REG_KEY_COUNT, 7'd1);
    sample_at(32'h0);
    sample_at(32'hffffffff);
    wait_idle();
    // unordered times, oversize count clamps to the full table
    load_track(NumSlots, 32'h00100000);
    write_key(10, 32'h00000001, rand_value());
    wait_idle();
    cfg_write(REG_KEY_COUNT, 7'd127);
    for (int k = 0; k < 6; k++) sample_at(pick_time(NumSlots));
    sample_at(32'hffffffff);
    wait_idle();
  endtask

  task automatic test_random(int items);
    int n;
    int done;
    done = 0;
    while (done < items) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(64, 33) : $urandom_range(8, 1);
      load_track(n, ($urandom_range(1)) ? 32'h00000040 : 32'h00800000);
      done += n;
      wait_idle();
      cfg_write(REG_KEY_COUNT, 7'(n));
      cfg_write(3'($urandom_range(4, 1)), $urandom());
      repeat ($urandom_range(20, 4)) begin
        if ($urandom_range(9) == 0)
          write_key($urandom_range(n - 1), pick_time(n), rand_value());
        else
          sample_at(pick_time(n));
        done++;
      end
      wait_idle();
    end
  endtask

  initial begin
    err_count = 0;
    cycle_count = 0;
    gap_pct = 24;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_WRITE;
    in_key_index = '0;
    in_key_time = '0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    in_w = '0;
    in_sample_time = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_count = '0;
    for (int c = 0; c < 4; c++) const_val[c] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_constant();
    test_directed();
    test_random(300);
    gap_pct = 78;
    test_random(300);
    gap_pct = 0;
    test_random(300);
    cfg_write(REG_KEY_COUNT, 7'd0);
    sample_at(32'h0);
    wait_idle();
    if (err_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
